### src/cpob_pkg.sv
// Shared types and register codes for the closest point on oriented box block.
package cpob_pkg;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [32:0] offs_t;
    typedef logic signed [15:0] quat_t;
    typedef logic        [30:0] size_t;
    typedef logic signed [20:0] ent_t;
    typedef logic signed [31:0] prod_q_t;
    typedef logic signed [53:0] dterm_t;
    typedef logic signed [52:0] uterm_t;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_SIZE_X = 3'd0;
    localparam cfg_idx_t REG_SIZE_Y = 3'd1;
    localparam cfg_idx_t REG_SIZE_Z = 3'd2;
    localparam cfg_idx_t REG_QUAT_W = 3'd3;
    localparam cfg_idx_t REG_QUAT_X = 3'd4;
    localparam cfg_idx_t REG_QUAT_Y = 3'd5;
    localparam cfg_idx_t REG_QUAT_Z = 3'd6;

    localparam size_t SIZE_RESET = 31'd65536;
    localparam quat_t QUAT_ONE   = 16'sd16384;

endpackage

### src/cpob_axes.sv
// Two pipeline stages: quaternion products and offset, then rounded rotation matrix.
module cpob_axes
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cpob_pkg::quat_t     qw,
    input  cpob_pkg::quat_t     qx,
    input  cpob_pkg::quat_t     qy,
    input  cpob_pkg::quat_t     qz,
    input  cpob_pkg::coord_t    pnt [3],
    input  cpob_pkg::coord_t    ctr [3],
    output logic                dn_valid,
    input  logic                dn_stall,
    output cpob_pkg::ent_t      mat [3][3],
    output cpob_pkg::offs_t     offs [3],
    output cpob_pkg::coord_t    ctr_out [3]
);

    logic             s1_valid_reg, s2_valid_reg;
    logic             s1_en, s2_en;
    cpob_pkg::prod_q_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    cpob_pkg::offs_t   d1_reg [3];
    cpob_pkg::coord_t  c1_reg [3];
    cpob_pkg::ent_t    a_reg  [3][3];
    cpob_pkg::offs_t   d2_reg [3];
    cpob_pkg::coord_t  c2_reg [3];
    logic signed [34:0] m [3][3];
    cpob_pkg::ent_t    a_next [3][3];
    logic signed [34:0] one_q28;
    logic signed [34:0] rnd;

    assign s2_en    = !s2_valid_reg || !dn_stall;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;
    assign dn_valid = s2_valid_reg;

    assign one_q28 = 35'sd268435456;
    assign rnd     = 35'sd8192;

    // Matrix entries are exact in Q28, then rounded half up to Q14.
    always_comb
    begin
        m[0][0] = one_q28 - 35'(2 * (35'(yy_reg) + 35'(zz_reg)));
        m[0][1] = 35'(2 * (35'(xy_reg) - 35'(wz_reg)));
        m[0][2] = 35'(2 * (35'(xz_reg) + 35'(wy_reg)));
        m[1][0] = 35'(2 * (35'(xy_reg) + 35'(wz_reg)));
        m[1][1] = one_q28 - 35'(2 * (35'(xx_reg) + 35'(zz_reg)));
        m[1][2] = 35'(2 * (35'(yz_reg) - 35'(wx_reg)));
        m[2][0] = 35'(2 * (35'(xz_reg) - 35'(wy_reg)));
        m[2][1] = 35'(2 * (35'(yz_reg) + 35'(wx_reg)));
        m[2][2] = one_q28 - 35'(2 * (35'(xx_reg) + 35'(yy_reg)));
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_next[r][k] = 21'((m[r][k] + rnd) >>> 14);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            wy_reg <= qw * qy;
            wz_reg <= qw * qz;
            for (int r = 0; r < 3; r++)
            begin
                d1_reg[r] <= 33'(pnt[r]) - 33'(ctr[r]);
                c1_reg[r] <= ctr[r];
            end
        end
        if (s2_en)
        begin
            a_reg  <= a_next;
            d2_reg <= d1_reg;
            c2_reg <= c1_reg;
        end
    end

    assign mat     = a_reg;
    assign offs    = d2_reg;
    assign ctr_out = c2_reg;

endmodule

### src/cpob_project.sv
// Two pipeline stages: axis projection products, then summed, rounded and clamped coordinates.
module cpob_project
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  cpob_pkg::size_t     size [3],
    input  cpob_pkg::ent_t      mat [3][3],
    input  cpob_pkg::offs_t     offs [3],
    input  cpob_pkg::coord_t    ctr [3],
    output logic                dn_valid,
    input  logic                dn_stall,
    output cpob_pkg::ent_t      mat_out [3][3],
    output cpob_pkg::coord_t    ctr_out [3],
    output cpob_pkg::coord_t    coord [3],
    output logic                in_box
);

    logic             s3_valid_reg, s4_valid_reg;
    logic             s3_en, s4_en;
    cpob_pkg::dterm_t pr_reg [3][3];
    cpob_pkg::ent_t   a3_reg [3][3];
    cpob_pkg::ent_t   a4_reg [3][3];
    cpob_pkg::coord_t c3_reg [3];
    cpob_pkg::coord_t c4_reg [3];
    cpob_pkg::coord_t u_reg  [3];
    logic             inside_reg;
    cpob_pkg::coord_t u_next [3];
    logic             inside_next;
    logic signed [55:0] dot  [3];
    logic signed [42:0] s    [3];
    logic signed [42:0] lim  [3];

    assign s4_en    = !s4_valid_reg || !dn_stall;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign up_stall = !s3_en;
    assign dn_valid = s4_valid_reg;

    // Coordinates are Q17 here, so the full size is the half-size limit.
    always_comb
    begin
        inside_next = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            dot[k] = 56'(pr_reg[0][k]) + 56'(pr_reg[1][k]) + 56'(pr_reg[2][k]);
            s[k]   = 43'((dot[k] + 56'sd4096) >>> 13);
            lim[k] = $signed({12'd0, size[k]});
            if (s[k] > lim[k])
            begin
                u_next[k]   = 32'(lim[k]);
                inside_next = 1'b0;
            end
            else if (s[k] < -lim[k])
            begin
                u_next[k]   = 32'(-lim[k]);
                inside_next = 1'b0;
            end
            else
            begin
                u_next[k] = 32'(s[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pr_reg[r][k] <= offs[r] * mat[r][k];
                end
            end
            a3_reg <= mat;
            c3_reg <= ctr;
        end
        if (s4_en)
        begin
            u_reg      <= u_next;
            inside_reg <= inside_next;
            a4_reg     <= a3_reg;
            c4_reg     <= c3_reg;
        end
    end

    assign mat_out = a4_reg;
    assign ctr_out = c4_reg;
    assign coord   = u_reg;
    assign in_box  = inside_reg;

endmodule

### src/cpob_rebuild.sv
// Two pipeline stages: world offset products, then rounding, center add and saturation.
module cpob_rebuild
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  cpob_pkg::ent_t      mat [3][3],
    input  cpob_pkg::coord_t    ctr [3],
    input  cpob_pkg::coord_t    coord [3],
    input  logic                in_box,
    output logic                dn_valid,
    input  logic                dn_stall,
    output cpob_pkg::coord_t    nearest [3],
    output logic                inside_out
);

    localparam logic signed [40:0] SAT_HI = 41'sd2147483647;
    localparam logic signed [40:0] SAT_LO = -41'sd2147483648;

    logic             s5_valid_reg, s6_valid_reg;
    logic             s5_en, s6_en;
    cpob_pkg::uterm_t q_reg [3][3];
    cpob_pkg::coord_t c5_reg [3];
    logic             in5_reg;
    cpob_pkg::coord_t n_reg [3];
    logic             in6_reg;
    cpob_pkg::coord_t n_next [3];
    logic signed [54:0] acc [3];
    logic signed [40:0] v   [3];

    assign s6_en    = !s6_valid_reg || !dn_stall;
    assign s5_en    = !s5_valid_reg || s6_en;
    assign up_stall = !s5_en;
    assign dn_valid = s6_valid_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 55'(q_reg[r][0]) + 55'(q_reg[r][1]) + 55'(q_reg[r][2]);
            v[r]   = 41'((acc[r] + 55'sd16384) >>> 15) + 41'(c5_reg[r]);
            if (v[r] > SAT_HI)
            begin
                n_next[r] = 32'(SAT_HI);
            end
            else if (v[r] < SAT_LO)
            begin
                n_next[r] = 32'(SAT_LO);
            end
            else
            begin
                n_next[r] = 32'(v[r]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_en)
            begin
                s5_valid_reg <= up_valid;
            end
            if (s6_en)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    q_reg[r][k] <= coord[k] * mat[r][k];
                end
            end
            c5_reg  <= ctr;
            in5_reg <= in_box;
        end
        if (s6_en)
        begin
            n_reg   <= n_next;
            in6_reg <= in5_reg;
        end
    end

    assign nearest    = n_reg;
    assign inside_out = in6_reg;

endmodule

### src/closest_point_on_oriented_box.sv
// Top level of the closest point on oriented box pipeline with its configuration registers.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   point_x/y/z, center_x/y/z
//   output   out        out_valid/out_stall nearest_x/y/z, inside_res
//   config   in         cfg_wr_en           cfg_index, cfg_data
//
// The pipeline has six register stages, s1 to s6, which an input item passes
// in order on its way to the output ports; one item can enter every cycle
// unless a stall has backed up to the input. The depth is set by the three
// multiply-then-sum steps (quaternion to matrix, projection, rebuild), each
// split into a product stage and a sum stage.
// Reset clears all valid bits and loads a unit box with identity orientation.
// A stall holds only the stages that are full, so bubbles are squeezed out;
// input is stalled only once all six stages hold items behind a waiting result.
module closest_point_on_oriented_box
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  cpob_pkg::cfg_idx_t         cfg_index,
    input  logic [30:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  cpob_pkg::coord_t           point_x,
    input  cpob_pkg::coord_t           point_y,
    input  cpob_pkg::coord_t           point_z,
    input  cpob_pkg::coord_t           center_x,
    input  cpob_pkg::coord_t           center_y,
    input  cpob_pkg::coord_t           center_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output cpob_pkg::coord_t           nearest_x,
    output cpob_pkg::coord_t           nearest_y,
    output cpob_pkg::coord_t           nearest_z,
    output logic                       inside_res
);

    cpob_pkg::size_t  size_reg [3];
    cpob_pkg::quat_t  qw_reg, qx_reg, qy_reg, qz_reg;

    cpob_pkg::coord_t pnt [3];
    cpob_pkg::coord_t ctr [3];

    logic             ax_valid, ax_stall;
    cpob_pkg::ent_t   ax_mat [3][3];
    cpob_pkg::offs_t  ax_offs [3];
    cpob_pkg::coord_t ax_ctr [3];

    logic             pj_valid, pj_stall;
    cpob_pkg::ent_t   pj_mat [3][3];
    cpob_pkg::coord_t pj_ctr [3];
    cpob_pkg::coord_t pj_coord [3];
    logic             pj_inside;

    cpob_pkg::coord_t nearest [3];

    // Register file. Writes beyond the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[0] <= cpob_pkg::SIZE_RESET;
            size_reg[1] <= cpob_pkg::SIZE_RESET;
            size_reg[2] <= cpob_pkg::SIZE_RESET;
            qw_reg      <= cpob_pkg::QUAT_ONE;
            qx_reg      <= '0;
            qy_reg      <= '0;
            qz_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cpob_pkg::REG_SIZE_X: size_reg[0] <= cfg_data;
                cpob_pkg::REG_SIZE_Y: size_reg[1] <= cfg_data;
                cpob_pkg::REG_SIZE_Z: size_reg[2] <= cfg_data;
                cpob_pkg::REG_QUAT_W: qw_reg      <= cfg_data[15:0];
                cpob_pkg::REG_QUAT_X: qx_reg      <= cfg_data[15:0];
                cpob_pkg::REG_QUAT_Y: qy_reg      <= cfg_data[15:0];
                cpob_pkg::REG_QUAT_Z: qz_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign pnt[0] = point_x;
    assign pnt[1] = point_y;
    assign pnt[2] = point_z;
    assign ctr[0] = center_x;
    assign ctr[1] = center_y;
    assign ctr[2] = center_z;

    cpob_axes u_axes
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .qw       (qw_reg),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .qz       (qz_reg),
        .pnt      (pnt),
        .ctr      (ctr),
        .dn_valid (ax_valid),
        .dn_stall (ax_stall),
        .mat      (ax_mat),
        .offs     (ax_offs),
        .ctr_out  (ax_ctr)
    );

    cpob_project u_project
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ax_valid),
        .up_stall (ax_stall),
        .size     (size_reg),
        .mat      (ax_mat),
        .offs     (ax_offs),
        .ctr      (ax_ctr),
        .dn_valid (pj_valid),
        .dn_stall (pj_stall),
        .mat_out  (pj_mat),
        .ctr_out  (pj_ctr),
        .coord    (pj_coord),
        .in_box   (pj_inside)
    );

    cpob_rebuild u_rebuild
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (pj_valid),
        .up_stall   (pj_stall),
        .mat        (pj_mat),
        .ctr        (pj_ctr),
        .coord      (pj_coord),
        .in_box     (pj_inside),
        .dn_valid   (out_valid),
        .dn_stall   (out_stall),
        .nearest    (nearest),
        .inside_out (inside_res)
    );

    assign nearest_x = nearest[0];
    assign nearest_y = nearest[1];
    assign nearest_z = nearest[2];

endmodule

### src/cpob_checker.sv
// Port-level checks for the closest point on oriented box block, with its bind.
module cpob_checker
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input cpob_pkg::coord_t        nearest_x,
    input logic                    inside_res
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // With no result waiting, every stage can move, so input is never held.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage is empty");

    // A transfer accepted while no result waits shows a result if the output is not stalled meanwhile.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid && !out_stall) ##1 !out_stall ##1 !out_stall
        ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result did not appear after six cycles");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(nearest_x) && $stable(inside_res))
        else $error("stalled result changed");

endmodule

bind closest_point_on_oriented_box cpob_checker u_cpob_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .nearest_x  (nearest_x),
    .inside_res (inside_res)
);
